// ===== hdl/cohm_pkg.sv =====
// Shared constants, codes and control/status types of the coalesced hash map.
`timescale 1ns / 1ps
package cohm_pkg;

    localparam int SLOTS  = 256;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = IDX_W + 1;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 9;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;
    localparam int MARK_W = 2;
    localparam int META_W = MARK_W + LINK_W;
    localparam int KV_W   = KEY_W + VAL_W;
    localparam int IN_W   = 104;
    localparam int OUT_W  = 48;

    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL     = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_REMOVED = 2'd2;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
    localparam logic [IDX_W-1:0]  STEP_LAST = IDX_W'(SLOTS - 1);

    typedef struct packed {
        logic              load;
        logic              save_home;
        logic              follow;
        logic              scan;
        logic              wr_hit_val;
        logic              wr_hit_rm;
        logic              wr_home_ins;
        logic              wr_np;
        logic              wr_home_link;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              set_res;
        logic              res_found;
        logic [STS_W-1:0]  res_status;
        logic              res_use_val;
        logic              out_load;
    } dp_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MARK_W-1:0] mark;
        logic              key_eq;
        logic              link_end;
        logic              step_last;
        logic              home_live;
        logic              free_zero;
        logic              out_busy;
    } dp_sts_t;

endpackage

// ===== hdl/coalesced_hash_map.sv =====
// Top level of the coalesced-chaining hash map with streaming ports.
// An operation checks the home slot, then each further chain slot in turn; a set that
// needs a free slot moves the free pointer down past non-empty slots, then writes both.
// Throughput: one operation at a time; the walk through the slot memories
// (one registered read per chain step) sets the rate.
// Reset (aresetn low, synchronous): all slots empty, free pointer at the top.
`timescale 1ns / 1ps
module coalesced_hash_map (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // command[1:0], key[65:2], value[97:66], zero pad to 104 bits
    input  logic [cohm_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // found[0], value_out[32:1], status[34:33], entry_count[43:35], zero pad
    output logic [cohm_pkg::OUT_W-1:0]  m_tdata
);

    cohm_pkg::dp_ctl_t ctl;
    cohm_pkg::dp_sts_t sts;

    // Controller: decide each step from the datapath status.
    cohm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Datapath: hold slots, pointers and the result register for the transfer.
    cohm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/cohm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cohm_dp.sv =====
// Datapath: slot memories, chain and free pointers, counters and result register.
`timescale 1ns / 1ps
module cohm_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cohm_pkg::dp_ctl_t        ctl,
    output cohm_pkg::dp_sts_t        sts,
    input  logic [cohm_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [cohm_pkg::OUT_W-1:0] m_tdata
);

    localparam int IW = cohm_pkg::IDX_W;
    localparam int LW = cohm_pkg::LINK_W;

    logic [cohm_pkg::CMD_W-1:0]  cmd_reg;
    logic [cohm_pkg::KEY_W-1:0]  key_reg;
    logic [cohm_pkg::VAL_W-1:0]  val_reg;
    logic [IW-1:0]               cur_reg;
    logic [IW-1:0]               step_reg;
    logic [cohm_pkg::MARK_W-1:0] hm_mark_reg;
    logic [LW-1:0]               hm_link_reg;
    logic [cohm_pkg::KEY_W-1:0]  hk_reg;
    logic [cohm_pkg::VAL_W-1:0]  hv_reg;
    logic [LW-1:0]               free_reg;
    logic [cohm_pkg::CNT_W-1:0]  cnt_reg;
    logic                        res_found_reg;
    logic [cohm_pkg::VAL_W-1:0]  res_val_reg;
    logic [cohm_pkg::STS_W-1:0]  res_status_reg;
    logic                        m_tvalid_reg;
    logic [cohm_pkg::OUT_W-1:0]  m_tdata_reg;
    logic [cohm_pkg::SLOTS-1:0]  valid_reg;
    logic                        vq_reg;

    logic [cohm_pkg::KEY_W-1:0]  key_in;
    logic [IW-1:0]               home_idx;
    logic [cohm_pkg::META_W-1:0] meta_rdata, meta_wdata;
    logic [cohm_pkg::KV_W-1:0]   kv_rdata, kv_wdata;
    logic [IW-1:0]               raddr, meta_waddr, kv_waddr;
    logic                        meta_we, kv_we;
    logic [cohm_pkg::MARK_W-1:0] rd_mark, hm_mark;
    logic [LW-1:0]               rd_link, hm_link;
    logic [cohm_pkg::KEY_W-1:0]  rd_key;
    logic [cohm_pkg::VAL_W-1:0]  rd_val;
    logic [LW-1:0]               free_m1;
    logic                        own;

    assign key_in   = s_tdata[cohm_pkg::CMD_W +: cohm_pkg::KEY_W];
    assign home_idx = key_reg[IW-1:0];
    assign free_m1  = free_reg - LW'(1);

    // Slots never written read as empty with a null link.
    always_comb begin
        if (vq_reg) begin
            rd_mark = meta_rdata[LW +: cohm_pkg::MARK_W];
            rd_link = meta_rdata[LW-1:0];
        end else begin
            rd_mark = cohm_pkg::MARK_EMPTY;
            rd_link = cohm_pkg::NULL_LINK;
        end
    end
    assign rd_key = kv_rdata[cohm_pkg::VAL_W +: cohm_pkg::KEY_W];
    assign rd_val = kv_rdata[cohm_pkg::VAL_W-1:0];

    assign hm_mark = ctl.save_home ? rd_mark : hm_mark_reg;
    assign hm_link = ctl.save_home ? rd_link : hm_link_reg;
    assign own     = (hk_reg[IW-1:0] == home_idx);

    always_comb begin
        priority if (ctl.load) begin
            raddr = key_in[IW-1:0];
        end else if (ctl.follow) begin
            raddr = rd_link[IW-1:0];
        end else begin
            raddr = free_m1[IW-1:0];
        end
    end

    always_comb begin
        meta_we    = 1'b1;
        meta_waddr = cur_reg;
        meta_wdata = {cohm_pkg::MARK_REMOVED, rd_link};
        priority if (ctl.wr_hit_rm) begin
            meta_waddr = cur_reg;
            meta_wdata = {cohm_pkg::MARK_REMOVED, rd_link};
        end else if (ctl.wr_home_ins) begin
            meta_waddr = home_idx;
            meta_wdata = {cohm_pkg::MARK_LIVE, hm_link};
        end else if (ctl.wr_np) begin
            meta_waddr = free_reg[IW-1:0];
            meta_wdata = {cohm_pkg::MARK_LIVE, hm_link_reg};
        end else if (ctl.wr_home_link) begin
            meta_waddr = home_idx;
            meta_wdata = {cohm_pkg::MARK_LIVE, free_reg};
        end else begin
            meta_we = 1'b0;
        end
    end

    always_comb begin
        kv_we    = 1'b1;
        kv_waddr = home_idx;
        kv_wdata = {key_reg, val_reg};
        priority if (ctl.wr_hit_val) begin
            kv_waddr = cur_reg;
        end else if (ctl.wr_home_ins) begin
            kv_waddr = home_idx;
        end else if (ctl.wr_np) begin
            kv_waddr = free_reg[IW-1:0];
            if (!own) begin
                kv_wdata = {hk_reg, hv_reg};
            end
        end else if (ctl.wr_home_link) begin
            kv_we = !own;
        end else begin
            kv_we = 1'b0;
        end
    end

    cohm_ram #(.WIDTH(cohm_pkg::META_W), .DEPTH(cohm_pkg::SLOTS)) u_meta (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (raddr),
        .rdata (meta_rdata)
    );

    cohm_ram #(.WIDTH(cohm_pkg::KV_W), .DEPTH(cohm_pkg::SLOTS)) u_kv (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            free_reg     <= cohm_pkg::NULL_LINK;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (meta_we) begin
                valid_reg[meta_waddr] <= 1'b1;
            end
            if (ctl.scan) begin
                free_reg <= free_m1;
            end
            if (ctl.cnt_inc) begin
                cnt_reg <= cnt_reg + cohm_pkg::CNT_W'(1);
            end else if (ctl.cnt_dec && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - cohm_pkg::CNT_W'(1);
            end
            if (ctl.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        vq_reg <= valid_reg[raddr];
        if (ctl.load) begin
            cmd_reg  <= s_tdata[cohm_pkg::CMD_W-1:0];
            key_reg  <= key_in;
            val_reg  <= s_tdata[cohm_pkg::CMD_W + cohm_pkg::KEY_W +: cohm_pkg::VAL_W];
            cur_reg  <= key_in[IW-1:0];
            step_reg <= '0;
        end else if (ctl.follow) begin
            cur_reg  <= rd_link[IW-1:0];
            step_reg <= step_reg + IW'(1);
        end
        if (ctl.save_home) begin
            hm_mark_reg <= rd_mark;
            hm_link_reg <= rd_link;
            hk_reg      <= rd_key;
            hv_reg      <= rd_val;
        end
        if (ctl.set_res) begin
            res_found_reg  <= ctl.res_found;
            res_status_reg <= ctl.res_status;
            res_val_reg    <= ctl.res_use_val ? rd_val : '0;
        end
        if (ctl.out_load) begin
            m_tdata_reg <= {4'd0, cnt_reg, res_status_reg, res_val_reg, res_found_reg};
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.mark      = rd_mark;
    assign sts.key_eq    = (rd_key == key_reg);
    assign sts.link_end  = rd_link[LW-1];
    assign sts.step_last = (step_reg == cohm_pkg::STEP_LAST);
    assign sts.home_live = (hm_mark == cohm_pkg::MARK_LIVE);
    assign sts.free_zero = (free_reg == '0);
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/cohm_ctrl.sv =====
// Controller: sequences chain walk, free-slot scan, slot writes and result hand-off.
`timescale 1ns / 1ps
module cohm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cohm_pkg::dp_sts_t sts,
    output cohm_pkg::dp_ctl_t ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHK_HOME = 3'd1;
    localparam logic [2:0] S_CHK_WALK = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_FCHK     = 3'd4;
    localparam logic [2:0] S_WR2      = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       hit, stop, known;

    assign hit   = (sts.mark == cohm_pkg::MARK_LIVE) && sts.key_eq;
    assign stop  = sts.link_end || sts.step_last;
    assign known = (sts.cmd == cohm_pkg::CMD_SET) || (sts.cmd == cohm_pkg::CMD_QUERY)
                   || (sts.cmd == cohm_pkg::CMD_REMOVE);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = S_CHK_HOME;
                end
            end
            S_CHK_HOME, S_CHK_WALK: begin
                ctl.save_home = (state_reg == S_CHK_HOME);
                priority if (!known) begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = cohm_pkg::ST_OK;
                    state_next     = S_FIN;
                end else if (hit) begin
                    ctl.set_res   = 1'b1;
                    ctl.res_found = 1'b1;
                    if (sts.cmd == cohm_pkg::CMD_SET) begin
                        ctl.wr_hit_val = 1'b1;
                    end else begin
                        ctl.res_use_val = 1'b1;
                        if (sts.cmd == cohm_pkg::CMD_REMOVE) begin
                            ctl.wr_hit_rm = 1'b1;
                            ctl.cnt_dec   = 1'b1;
                        end
                    end
                    state_next = S_FIN;
                end else if (stop || (state_reg == S_CHK_HOME
                                      && sts.mark == cohm_pkg::MARK_EMPTY)) begin
                    // Key absent: place it or report the miss.
                    if (sts.cmd != cohm_pkg::CMD_SET) begin
                        ctl.set_res    = 1'b1;
                        ctl.res_status = cohm_pkg::ST_NOT_FOUND;
                        state_next     = S_FIN;
                    end else if (sts.home_live) begin
                        state_next = S_SCAN;
                    end else begin
                        ctl.wr_home_ins = 1'b1;
                        ctl.cnt_inc     = 1'b1;
                        ctl.set_res     = 1'b1;
                        state_next      = S_FIN;
                    end
                end else begin
                    ctl.follow = 1'b1;
                    state_next = S_CHK_WALK;
                end
            end
            S_SCAN: begin
                if (sts.free_zero) begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = cohm_pkg::ST_FULL;
                    state_next     = S_FIN;
                end else begin
                    ctl.scan   = 1'b1;
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                if (sts.mark == cohm_pkg::MARK_EMPTY) begin
                    ctl.wr_np  = 1'b1;
                    state_next = S_WR2;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_WR2: begin
                ctl.wr_home_link = 1'b1;
                ctl.cnt_inc      = 1'b1;
                ctl.set_res      = 1'b1;
                state_next       = S_FIN;
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
